/* sv/lru_page_replacement_unit_assert.svh */
// Assertion macros, clocked on clk, off during rst.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LRU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru assertion failed");

// Next-cycle implication.
`define LRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru assertion failed");

`endif

/* sv/lrupr_pkg.sv */
`default_nettype none
package lrupr_pkg;

  localparam int MAX_FRAME_SLOTS = 7;
  localparam int PAGE_BITS       = 8;
  localparam int FAULT_BITS      = 16;

  localparam int SLOT_BITS  = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;
  localparam int RANK_BITS  = SLOT_BITS;
  localparam int COUNT_BITS = $clog2(MAX_FRAME_SLOTS + 1);

  localparam int FRAME_COUNT_RESET = 3;

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FAULT_BITS-1:0] fault_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam rank_t  RANK_MAX  = rank_t'(MAX_FRAME_SLOTS - 1);
  localparam fault_t FAULT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // one frame as seen by the scan
  typedef struct packed {
    logic  full;
    page_t page;
    rank_t rank;
  } frame_ent_t;

  // frame table update command
  typedef struct packed {
    logic   write;
    logic   clear;
    slot_t  frame;
    page_t  page;
    logic   was_full;
    rank_t  old_rank;
    count_t count;
  } frame_upd_t;

  typedef struct packed {
    logic   hit;
    slot_t  frame;
    fault_t fault_total;
  } result_t;

endpackage
`default_nettype wire

/* sv/lrupr_frames.sv */
`default_nettype none
module lrupr_frames
  import lrupr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire count_t     rd_idx,
  output frame_ent_t      rd_ent,
  input  wire frame_upd_t upd
);

  page_t frame_page [MAX_FRAME_SLOTS];
  logic  frame_full [MAX_FRAME_SLOTS];
  rank_t age_rank   [MAX_FRAME_SLOTS];

  slot_t rd_slot;
  assign rd_slot = rd_idx[SLOT_BITS-1:0];

  always_comb begin
    rd_ent.full = frame_full[rd_slot];
    rd_ent.page = frame_page[rd_slot];
    rd_ent.rank = age_rank[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_FRAME_SLOTS; j++) begin
        frame_full[j] <= 1'b0;
        age_rank[j]   <= '0;
      end
    end else if (upd.write) begin
      for (int j = 0; j < MAX_FRAME_SLOTS; j++) begin
        if (upd.clear) begin
          frame_full[j] <= 1'b0;
          age_rank[j]   <= '0;
          frame_page[j] <= '0;
        end else if (slot_t'(j) == upd.frame) begin
          frame_full[j] <= 1'b1;
          age_rank[j]   <= '0;
          frame_page[j] <= upd.page;
        end else if (count_t'(j) < upd.count && frame_full[j] &&
                     (!upd.was_full || age_rank[j] < upd.old_rank) &&
                     age_rank[j] < RANK_MAX) begin
          age_rank[j] <= age_rank[j] + rank_t'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/lrupr_ctrl.sv */
`default_nettype none
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire page_t      in_page,
  input  wire logic       in_last,
  input  wire count_t     frame_count,
  output count_t          rd_idx,
  input  wire frame_ent_t rd_ent,
  output frame_upd_t      upd,
  input  wire logic       out_free,
  output logic            res_load,
  output result_t         res
);

  state_t state, state_next;

  page_t  page_r;
  logic   last_r;
  count_t n_r;
  count_t idx;
  logic   emp_found;
  slot_t  emp_idx;
  slot_t  old_idx;
  rank_t  old_rank;
  logic   hit_r;
  slot_t  f_r;
  logic   was_full_r;
  rank_t  f_rank_r;
  fault_t fault_counter;

  logic   match, last_slot, emp_found_n, old_take;
  slot_t  cur_slot, emp_idx_n, old_idx_n, victim;
  rank_t  old_rank_n;
  fault_t fault_next;

  // compare unit: one frame per cycle
  always_comb begin
    cur_slot    = idx[SLOT_BITS-1:0];
    match       = rd_ent.full && (rd_ent.page == page_r);
    last_slot   = (idx == n_r - count_t'(1));
    emp_found_n = emp_found || !rd_ent.full;
    emp_idx_n   = emp_found ? emp_idx : cur_slot;
    old_take    = (idx == '0) || (rd_ent.rank > old_rank);
    old_idx_n   = old_take ? cur_slot : old_idx;
    old_rank_n  = old_take ? rd_ent.rank : old_rank;
    victim      = emp_found_n ? emp_idx_n : old_idx_n;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (match || last_slot) state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    fault_next = (hit_r || fault_counter == FAULT_MAX) ? fault_counter
               : fault_counter + fault_t'(1);
    in_ready     = (state == ST_IDLE);
    rd_idx       = idx;
    res_load     = (state == ST_UPDATE) && out_free;
    upd.write    = res_load;
    upd.clear    = last_r;
    upd.frame    = f_r;
    upd.page     = page_r;
    upd.was_full = was_full_r;
    upd.old_rank = f_rank_r;
    upd.count    = n_r;
    res.hit         = hit_r;
    res.frame       = f_r;
    res.fault_total = fault_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fault_counter <= '0;
    end else begin
      state <= state_next;
      if (res_load) fault_counter <= last_r ? '0 : fault_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        page_r    <= in_page;
        last_r    <= in_last;
        n_r       <= (frame_count == '0) ? count_t'(1)
                   : (frame_count > count_t'(MAX_FRAME_SLOTS)) ? count_t'(MAX_FRAME_SLOTS)
                   : frame_count;
        idx       <= '0;
        emp_found <= 1'b0;
      end
      ST_SCAN: begin
        idx       <= idx + count_t'(1);
        emp_found <= emp_found_n;
        emp_idx   <= emp_idx_n;
        old_idx   <= old_idx_n;
        old_rank  <= old_rank_n;
        if (match) begin
          hit_r      <= 1'b1;
          f_r        <= cur_slot;
          was_full_r <= 1'b1;
          f_rank_r   <= rd_ent.rank;
        end else begin
          hit_r      <= 1'b0;
          f_r        <= victim;
          was_full_r <= !emp_found_n;
          f_rank_r   <= old_rank_n;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/lru_page_replacement_unit.sv */
// Flow: a word is accepted in idle, then the scan reads frames 0..n-1, n = frames in use (1..7),
// and stops early on a hit; the update state then writes the table and loads the result.
// The scan reads one frame per cycle; a new word is accepted only after the last one's update.
// The output register lets the next word start while a result waits.
// Reset (rst, synchronous): all frames empty, ranks and fault count zero,
// frame_count back to 3.
`default_nettype none
module lru_page_replacement_unit
  import lrupr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] page
  input  wire logic        s_tlast,   // last_in_string
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [2:0] frame_index, [18:3] fault_total, zero pad
  output logic             m_tuser,   // hit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data   // frame_count
);

  `include "lru_page_replacement_unit_assert.svh"

  count_t     frame_count;
  count_t     rd_idx;
  frame_ent_t rd_ent;
  frame_upd_t upd;
  logic       out_free;
  logic       res_load;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= count_t'(FRAME_COUNT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      frame_count <= count_t'(cfg_data);
    end
  end

  lrupr_frames u_frames (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd_ent (rd_ent),
    .upd    (upd)
  );

  lrupr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_page     (page_t'(s_tdata)),
    .in_last     (s_tlast),
    .frame_count (frame_count),
    .rd_idx      (rd_idx),
    .rd_ent      (rd_ent),
    .upd         (upd),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= res.hit;
      m_tdata <= 24'({res.fault_total, res.frame});
    end
  end

  `LRU_ASSERT_NOW(a_upd_not_idle, upd.write, !s_tready)
  `LRU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `LRU_ASSERT_NEXT(a_result_after_upd, upd.write, m_tvalid)
  `LRU_ASSERT_NOW(a_upd_slot_free, upd.write, !m_tvalid || m_tready)

endmodule
`default_nettype wire

/* tb/tb_lru_page_replacement_unit.sv */
`timescale 1ns / 100ps
module tb_lru_page_replacement_unit;
  import lrupr_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int RANDOM_ITEMS    = 580;
  localparam int FAULT_RUN_ITEMS = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] page
  logic        s_tlast;   // last_in_string
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [2:0] frame_index, [18:3] fault_total, zero pad
  logic        m_tuser;   // hit
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;  // frame_count

  lru_page_replacement_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // frame table as the block should hold it
  page_t      frame_page [MAX_FRAME_SLOTS];
  bit         frame_full [MAX_FRAME_SLOTS];
  int         frame_age  [MAX_FRAME_SLOTS];
  fault_t     fault_count;
  logic [2:0] frames_setting;
  result_t    lookup_outcomes[$];

  int errors = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_frames();
    for (int j = 0; j < MAX_FRAME_SLOTS; j++) begin
      frame_page[j] = '0;
      frame_full[j] = 1'b0;
      frame_age[j]  = 0;
    end
    fault_count = '0;
  endfunction

  // make frame f the newest; empty frame counts as older than everything
  function automatic void touch_frame(input int f, input int n);
    int prior;
    prior = frame_full[f] ? frame_age[f] : MAX_FRAME_SLOTS;
    for (int j = 0; j < n; j++) begin
      if (j != f && frame_full[j] && frame_age[j] < prior && frame_age[j] < int'(RANK_MAX))
        frame_age[j]++;
    end
    frame_age[f] = 0;
  endfunction

  function automatic result_t replace_or_hit(input page_t pg, input bit last);
    result_t r;
    int n;
    int f;
    bit hit;
    bit found;
    n = (frames_setting == 3'd0) ? 1 : int'(frames_setting);
    if (n > MAX_FRAME_SLOTS) n = MAX_FRAME_SLOTS;
    hit = 1'b0;
    f = 0;
    for (int j = 0; j < n; j++) begin
      if (!hit && frame_full[j] && frame_page[j] == pg) begin
        hit = 1'b1;
        f = j;
      end
    end
    if (!hit) begin
      found = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (!found && !frame_full[j]) begin
          f = j;
          found = 1'b1;
        end
      end
      if (!found) begin
        f = 0;
        for (int j = 1; j < n; j++)
          if (frame_age[j] > frame_age[f]) f = j;
      end
    end
    touch_frame(f, n);
    if (!hit) begin
      frame_page[f] = pg;
      frame_full[f] = 1'b1;
      if (fault_count != FAULT_MAX) fault_count++;
    end
    r.hit = hit;
    r.frame = slot_t'(f);
    r.fault_total = fault_count;
    if (last) clear_frames();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  task automatic send_ref(input page_t pg, input bit last);
    int gap;
    gap = gap_len(src_idle);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pg;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lookup_outcomes.push_back(replace_or_hit(pg, last));
  endtask

  task automatic finish_phase();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (lookup_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frames(input logic [2:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    frames_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lookup_outcomes.size() == 0) begin
        report_mismatch("unexpected word", 32'(m_tdata), '0);
      end else begin
        want = lookup_outcomes.pop_front();
        if (m_tuser !== want.hit) report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
        if (m_tdata[2:0] !== want.frame)
          report_mismatch("frame_index", 32'(m_tdata[2:0]), 32'(want.frame));
        if (m_tdata[18:3] !== want.fault_total)
          report_mismatch("fault_total", 32'(m_tdata[18:3]), 32'(want.fault_total));
        if (m_tdata[23:19] !== '0) report_mismatch("pad bits", 32'(m_tdata[23:19]), '0);
      end
    end
  end

  // result side backpressure
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (sink_idle && $urandom_range(0, 99) < 30) stall = gap_len(1'b1);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("lru_page_replacement_unit test failed");
    $finish;
  end

  // reset setting of three frames, LRU eviction once full
  task automatic test_default_frames();
    send_ref(8'h00, 1'b0);
    send_ref(8'hFF, 1'b0);
    send_ref(8'h00, 1'b0);
    send_ref(8'h80, 1'b0);
    send_ref(8'h07, 1'b0);
    send_ref(8'hFF, 1'b0);
    send_ref(8'h80, 1'b1);
    finish_phase();
  endtask

  // zero frames behaves as one frame
  task automatic test_single_frame();
    write_frames(3'd0);
    send_ref(8'h05, 1'b0);
    send_ref(8'h05, 1'b0);
    send_ref(8'h06, 1'b0);
    send_ref(8'h05, 1'b1);
    finish_phase();
    write_frames(3'd1);
    send_ref(8'h5A, 1'b0);
    send_ref(8'h5A, 1'b1);
    finish_phase();
  endtask

  // shrink and regrow mid-string: parked frames keep pages, ranks may tie
  task automatic test_count_change();
    write_frames(3'd7);
    for (int i = 0; i < 7; i++) send_ref(page_t'(8'h10 + i), 1'b0);
    send_ref(8'h13, 1'b0);
    finish_phase();
    write_frames(3'd2);
    send_ref(8'h16, 1'b0);
    send_ref(8'h20, 1'b0);
    finish_phase();
    write_frames(3'd7);
    send_ref(8'h21, 1'b0);
    send_ref(8'h14, 1'b0);
    send_ref(8'h15, 1'b1);
    finish_phase();
  endtask

  // one frame, alternating pages back to back: each of those faults, then a repeated page hits
  task automatic test_fault_run();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    write_frames(3'd1);
    for (int i = 0; i < FAULT_RUN_ITEMS; i++) send_ref(i[0] ? 8'hA5 : 8'h5A, 1'b0);
    send_ref(8'hA5, 1'b0);
    send_ref(8'h3C, 1'b1);
    send_ref(8'h3C, 1'b1);
    finish_phase();
  endtask

  // strings over small working sets so hits and evictions both happen
  task automatic test_random_strings();
    int sent;
    int len;
    int base;
    int spread;
    bit ends;
    page_t pg;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      write_frames(3'($urandom_range(0, 7)));
      len = $urandom_range(1, 40);
      base = $urandom_range(0, 255);
      spread = $urandom_range(1, 10);
      ends = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0)
          pg = page_t'($urandom_range(0, 255));
        else
          pg = page_t'(base + $urandom_range(0, spread - 1));
        send_ref(pg, (ends && k == len - 1) || $urandom_range(0, 49) == 0);
      end
      sent += len;
      finish_phase();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    frames_setting = 3'(FRAME_COUNT_RESET);
    clear_frames();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_frames();
    test_single_frame();
    test_count_change();
    test_fault_run();
    test_random_strings();
    if (lookup_outcomes.size() != 0)
      report_mismatch("missing words", 32'(lookup_outcomes.size()), '0);
    if (errors == 0)
      $display("lru_page_replacement_unit test passed");
    else
      $display("lru_page_replacement_unit test failed");
    $finish;
  end

endmodule
